// ----- src/pwu_pkg.sv -----
package pwu_pkg;

  // landmark table geometry
  localparam int MaxLandmarks = 64;
  localparam int AddrW        = $clog2(MaxLandmarks);
  localparam int CountW       = 7;

  // heading reduction and rotation constants, Q2.30
  localparam int CordW     = 34;
  localparam int CordSteps = 24;
  localparam logic [45:0] TwoPiQ30 = 46'd6746518852;
  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [CordW-1:0] GainQ30 = 34'sd652032874;

  // weight arithmetic constants
  localparam logic [47:0] WeightOne = 48'h0001_0000_0000;
  localparam logic [47:0] WeightMax = 48'hFFFF_FFFF_FFFF;
  localparam logic [38:0] ExpCap    = 39'h40_0000_0000;
  localparam logic [32:0] OneQ32    = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_POSE = 2'd1,
    CMD_OBS  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_RANGE = 3'd0,
    REG_KX    = 3'd1,
    REG_KY    = 3'd2,
    REG_NORM  = 3'd3,
    REG_COUNT = 3'd4
  } reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_REDUCE,
    S_FOLD,
    S_CORDIC,
    S_XF_MUL,
    S_XF_SUM,
    S_SCAN,
    S_EXP_MUL,
    S_EXP_SUM,
    S_NE_MUL,
    S_NE_RCP,
    S_NE_DIV,
    S_NE_SQ,
    S_GAIN,
    S_WMUL,
    S_WSUM,
    S_DONE
  } state_t;

  // rotation vector handed from cell to cell
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
  } cordic_t;

  // arctangent of 2^-i in Q2.30
  function automatic logic signed [CordW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CordW-1:0] v;
    unique case (idx)
      5'd0:    v = 34'sd843314856;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043836;
      5'd3:    v = 34'sd133525158;
      5'd4:    v = 34'sd67021686;
      5'd5:    v = 34'sd33543515;
      5'd6:    v = 34'sd16775850;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194282;
      5'd9:    v = 34'sd2097149;
      5'd10:   v = 34'sd1048575;
      5'd11:   v = 34'sd524287;
      5'd12:   v = 34'sd262143;
      5'd13:   v = 34'sd131071;
      5'd14:   v = 34'sd65535;
      5'd15:   v = 34'sd32767;
      5'd16:   v = 34'sd16383;
      5'd17:   v = 34'sd8191;
      5'd18:   v = 34'sd4095;
      5'd19:   v = 34'sd2047;
      5'd20:   v = 34'sd1023;
      5'd21:   v = 34'sd511;
      5'd22:   v = 34'sd255;
      5'd23:   v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // floor(2^32 / n) for the series divisions
  function automatic logic [32:0] recip_q32(input logic [4:0] n);
    logic [32:0] v;
    unique case (n)
      5'd1:    v = 33'd4294967296;
      5'd2:    v = 33'd2147483648;
      5'd3:    v = 33'd1431655765;
      5'd4:    v = 33'd1073741824;
      5'd5:    v = 33'd858993459;
      5'd6:    v = 33'd715827882;
      5'd7:    v = 33'd613566756;
      5'd8:    v = 33'd536870912;
      5'd9:    v = 33'd477218588;
      5'd10:   v = 33'd429496729;
      5'd11:   v = 33'd390451572;
      5'd12:   v = 33'd357913941;
      5'd13:   v = 33'd330382099;
      5'd14:   v = 33'd306783378;
      5'd15:   v = 33'd286331153;
      5'd16:   v = 33'd268435456;
      5'd17:   v = 33'd252645135;
      5'd18:   v = 33'd238609294;
      5'd19:   v = 33'd226050910;
      5'd20:   v = 33'd214748364;
      5'd21:   v = 33'd204522252;
      5'd22:   v = 33'd195225786;
      5'd23:   v = 33'd186737708;
      default: v = 33'd4294967296;
    endcase
    return v;
  endfunction

endpackage

// ----- src/particle_weight_update_core.sv -----
// Particle measurement weight update. Issue an item with start while busy is low;
// command 0 loads a landmark slot (no result), command 1 sets the pose and
// heading and resets the weight to 1.0 (busy through 13 reduction steps, one
// fold and the 24-cell rotation chain), command 2 maps an observation, searches
// slots 0..landmark_count-1 (at most 64) for the nearest landmark in range, and
// updates the weight. An observation ends after the scan when no landmark
// matches, skips the exp series when the exponent saturates, and else runs up
// to 23 exp series terms; the landmark scan reads one slot per cycle from the
// landmark memory and the series runs term by term through its multiply,
// reciprocal and divide steps. Each result appears for exactly one cycle with done
// high and cannot be held off by the receiver. Configuration writes take effect
// at once and belong in idle time.
module particle_weight_update_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [5:0]         slot,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  input  logic signed [31:0] heading,
  input  logic               last,
  input  logic               wr_en,
  input  logic [2:0]         wr_addr,
  input  logic [31:0]        wr_data,
  output logic               done,
  output logic signed [31:0] map_x,
  output logic signed [31:0] map_y,
  output logic [5:0]         matched_slot,
  output logic               matched,
  output logic [47:0]        running_weight,
  output logic               final_res
);

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -36'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] absdiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [32:0] m;
    d = 33'(a) - 33'(b);
    m = d[32] ? -d : d;
    return m[31:0];
  endfunction

  function automatic logic signed [17:0] to_q16(input logic signed [pwu_pkg::CordW-1:0] v,
                                                input logic neg);
    logic signed [pwu_pkg::CordW:0] s;
    logic signed [17:0] c;
    s = (35'(v) + 35'sd8192) >>> 14;
    if (s > 35'sd131071) c = 18'sh1FFFF;
    else if (s < -35'sd131072) c = 18'sh20000;
    else c = s[17:0];
    return neg ? -c : c;
  endfunction

  function automatic logic [38:0] exp_term(input logic [63:0] hk, input logic [63:0] lo);
    logic [48:0] v;
    logic [38:0] r;
    v = 49'({hk[21:0], 16'b0}) + 49'(lo >> 16);
    if (hk >= 64'd4194304) r = pwu_pkg::ExpCap;
    else if (v > 49'(pwu_pkg::ExpCap)) r = pwu_pkg::ExpCap;
    else r = v[38:0];
    return r;
  endfunction

  // configuration registers
  logic [30:0] reach_limit;
  logic [31:0] inv_two_var_x, inv_two_var_y, norm_factor;
  logic [pwu_pkg::CountW-1:0] landmark_count;

  pwu_pkg::state_t state, state_next;
  logic accept, load_result;

  // particle state
  logic signed [31:0] pose_x, pose_y;
  logic signed [17:0] heading_cosine, heading_sine;
  logic [47:0] weight;

  // latched observation
  logic signed [31:0] obs_x, obs_y;
  logic last_q;

  // heading reduction
  logic [45:0] red_rem;
  logic red_neg;
  logic [3:0] red_step;
  logic [45:0] red_sub;
  logic signed [35:0] fr0, fr1, fr2;
  logic fold_neg_c, fold_neg;
  logic [4:0] cord_cnt;
  pwu_pkg::cordic_t link [pwu_pkg::CordSteps+1];

  // map transform
  logic signed [49:0] xc, ys, xs, yc;
  logic signed [50:0] acc_x, acc_y;
  logic signed [31:0] mx, my;
  logic [61:0] r2;

  // landmark scan
  logic [pwu_pkg::CountW-1:0] issue_idx, scan_cnt;
  logic v1, v2;
  logic [pwu_pkg::AddrW-1:0] idx1, idx2;
  logic signed [31:0] lm_x, lm_y;
  logic [63:0] sq_ax, sq_ay, sq_dx, sq_dy;
  logic [64:0] pair_sum, dist_sum;
  logic [63:0] obs_dist;
  logic qual, scan_end;
  logic found;
  logic [63:0] best, best_dx, best_dy;
  logic [pwu_pkg::AddrW-1:0] bslot;
  logic load_we;

  // exponent and series
  logic [63:0] hkx, lox, hky, loy;
  logic [39:0] e_sum;
  logic [31:0] ne_x, ne_v;
  logic [32:0] ne_t;
  logic signed [34:0] ne_sum, ne_sum_next;
  logic [4:0] ne_n;
  logic [64:0] ne_prod, ne_m;
  logic [31:0] q_est, q_fix;
  logic [36:0] q_rem;
  logic ne_exit;
  logic [32:0] sq_r;
  logic [2:0] sq_cnt;
  logic [64:0] sq_p, gain_p;
  logic [48:0] gain;

  // weight product
  logic [48:0] p_hi, p_m2;
  logic [47:0] p_m1, p_lo;
  logic [49:0] w_mid;
  logic [48:0] w_a;
  logic [50:0] w_r;
  logic [47:0] w_new;

  assign accept = start && !busy;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      reach_limit    <= 31'd3276800;
      inv_two_var_x  <= 32'd364089;
      inv_two_var_y  <= 32'd364089;
      norm_factor    <= 32'd115878;
      landmark_count <= '0;
    end else if (wr_en) begin
      unique case (pwu_pkg::reg_t'(wr_addr))
        pwu_pkg::REG_RANGE: reach_limit    <= wr_data[30:0];
        pwu_pkg::REG_KX:    inv_two_var_x  <= wr_data;
        pwu_pkg::REG_KY:    inv_two_var_y  <= wr_data;
        pwu_pkg::REG_NORM:  norm_factor    <= wr_data;
        pwu_pkg::REG_COUNT: landmark_count <= wr_data[pwu_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // landmark memories
  assign load_we = accept && (pwu_pkg::cmd_t'(command) == pwu_pkg::CMD_LOAD)
                   && ({1'b0, slot} < 7'(pwu_pkg::MaxLandmarks));

  pwu_ram #(.Width(32), .Depth(pwu_pkg::MaxLandmarks)) u_ram_x (
    .clk(clk), .we(load_we), .waddr(slot[pwu_pkg::AddrW-1:0]), .wdata(x_value),
    .raddr(issue_idx[pwu_pkg::AddrW-1:0]), .rdata(lm_x)
  );

  pwu_ram #(.Width(32), .Depth(pwu_pkg::MaxLandmarks)) u_ram_y (
    .clk(clk), .we(load_we), .waddr(slot[pwu_pkg::AddrW-1:0]), .wdata(y_value),
    .raddr(issue_idx[pwu_pkg::AddrW-1:0]), .rdata(lm_y)
  );

  // rotation chain
  assign link[0].x = pwu_pkg::GainQ30;
  assign link[0].y = '0;
  assign link[0].z = fr2[pwu_pkg::CordW-1:0];

  for (genvar i = 0; i < pwu_pkg::CordSteps; i++) begin : g_cell
    pwu_cordic_cell u_cell (
      .clk(clk), .step(5'(i)), .din(link[i]), .dout(link[i+1])
    );
  end

  // heading reduction step and fold into the right half plane
  always_comb begin
    red_sub = pwu_pkg::TwoPiQ30 << red_step;
    if (red_neg) fr0 = (red_rem == '0) ? '0 : 36'(pwu_pkg::TwoPiQ30) - 36'(red_rem);
    else fr0 = 36'(red_rem);
    fr1 = (fr0 > pwu_pkg::PiQ30) ? fr0 - 36'(pwu_pkg::TwoPiQ30) : fr0;
    fold_neg_c = 1'b0;
    fr2 = fr1;
    if (fr1 > pwu_pkg::HalfPiQ30) begin
      fr2 = fr1 - pwu_pkg::PiQ30;
      fold_neg_c = 1'b1;
    end else if (fr1 < -pwu_pkg::HalfPiQ30) begin
      fr2 = fr1 + pwu_pkg::PiQ30;
      fold_neg_c = 1'b1;
    end
  end

  // map transform sums
  always_comb begin
    acc_x = 51'(xc) - 51'(ys) + 51'sd32768;
    acc_y = 51'(xs) + 51'(yc) + 51'sd32768;
  end

  // scan compare
  always_comb begin
    scan_cnt = (landmark_count > pwu_pkg::CountW'(pwu_pkg::MaxLandmarks))
               ? pwu_pkg::CountW'(pwu_pkg::MaxLandmarks) : landmark_count;
    pair_sum = 65'(sq_ax) + 65'(sq_ay);
    qual = (sq_ax < 64'(r2)) && (sq_ay < 64'(r2)) && (pair_sum < 65'(r2));
    dist_sum = 65'(sq_dx) + 65'(sq_dy);
    obs_dist = dist_sum[64] ? '1 : dist_sum[63:0];
    scan_end = (issue_idx >= scan_cnt) && !v1 && !v2;
  end

  // exponent and series step
  always_comb begin
    e_sum = 40'(exp_term(hkx, lox)) + 40'(exp_term(hky, loy));
    ne_prod = 65'(ne_t) * 65'(ne_x);
    q_est = ne_m[63:32];
    q_rem = 37'(ne_v) - 37'(q_est) * 37'(ne_n);
    q_fix = (q_rem >= 37'(ne_n)) ? q_est + 32'd1 : q_est;
    ne_sum_next = ne_n[0] ? ne_sum - 35'($signed({3'b0, q_fix}))
                          : ne_sum + 35'($signed({3'b0, q_fix}));
    ne_exit = (ne_n == 5'd23) || (q_fix == '0);
    sq_p = 65'(sq_r[31:0]) * 65'(sq_r[31:0]) + 65'h8000_0000;
    gain_p = 65'(norm_factor) * 65'(sq_r) + 65'd32768;
  end

  // weight product combine
  always_comb begin
    w_mid = 50'(p_m1) + 50'(p_m2);
    w_a = 49'(p_lo) + 49'({w_mid[7:0], 24'b0});
    w_r = 51'({p_hi[31:0], 16'b0}) + 51'(w_mid >> 8) + 51'((50'(w_a) + 50'h8000_0000) >> 32);
    if (p_hi >= 49'h1_0000_0000) w_new = pwu_pkg::WeightMax;
    else if (w_r > 51'(pwu_pkg::WeightMax)) w_new = pwu_pkg::WeightMax;
    else w_new = w_r[47:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pwu_pkg::S_IDLE: begin
        if (accept) begin
          if (pwu_pkg::cmd_t'(command) == pwu_pkg::CMD_POSE) state_next = pwu_pkg::S_REDUCE;
          else if (pwu_pkg::cmd_t'(command) == pwu_pkg::CMD_OBS) state_next = pwu_pkg::S_XF_MUL;
        end
      end
      pwu_pkg::S_REDUCE:  if (red_step == '0) state_next = pwu_pkg::S_FOLD;
      pwu_pkg::S_FOLD:    state_next = pwu_pkg::S_CORDIC;
      pwu_pkg::S_CORDIC:  if (cord_cnt == 5'(pwu_pkg::CordSteps)) state_next = pwu_pkg::S_IDLE;
      pwu_pkg::S_XF_MUL:  state_next = pwu_pkg::S_XF_SUM;
      pwu_pkg::S_XF_SUM:  state_next = pwu_pkg::S_SCAN;
      pwu_pkg::S_SCAN: begin
        if (scan_end) state_next = found ? pwu_pkg::S_EXP_MUL : pwu_pkg::S_DONE;
      end
      pwu_pkg::S_EXP_MUL: state_next = pwu_pkg::S_EXP_SUM;
      pwu_pkg::S_EXP_SUM: begin
        state_next = (e_sum >= 40'(pwu_pkg::ExpCap)) ? pwu_pkg::S_GAIN : pwu_pkg::S_NE_MUL;
      end
      pwu_pkg::S_NE_MUL:  state_next = pwu_pkg::S_NE_RCP;
      pwu_pkg::S_NE_RCP:  state_next = pwu_pkg::S_NE_DIV;
      pwu_pkg::S_NE_DIV:  state_next = ne_exit ? pwu_pkg::S_NE_SQ : pwu_pkg::S_NE_MUL;
      pwu_pkg::S_NE_SQ:   if (sq_cnt == 3'd5) state_next = pwu_pkg::S_GAIN;
      pwu_pkg::S_GAIN:    state_next = pwu_pkg::S_WMUL;
      pwu_pkg::S_WMUL:    state_next = pwu_pkg::S_WSUM;
      pwu_pkg::S_WSUM:    state_next = pwu_pkg::S_DONE;
      pwu_pkg::S_DONE:    state_next = pwu_pkg::S_IDLE;
      default:            state_next = pwu_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy = (state != pwu_pkg::S_IDLE);
    load_result = (state == pwu_pkg::S_DONE);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pwu_pkg::S_IDLE;
      done           <= 1'b0;
      v1             <= 1'b0;
      v2             <= 1'b0;
      pose_x         <= '0;
      pose_y         <= '0;
      heading_cosine <= 18'sd65536;
      heading_sine   <= '0;
      weight         <= pwu_pkg::WeightOne;
    end else begin
      state <= state_next;
      done  <= load_result;
      v1    <= (state == pwu_pkg::S_SCAN) && (issue_idx < scan_cnt);
      v2    <= v1;
      if (accept && pwu_pkg::cmd_t'(command) == pwu_pkg::CMD_POSE) begin
        pose_x <= x_value;
        pose_y <= y_value;
        weight <= pwu_pkg::WeightOne;
      end
      if (state == pwu_pkg::S_CORDIC && cord_cnt == 5'(pwu_pkg::CordSteps)) begin
        heading_cosine <= to_q16(link[pwu_pkg::CordSteps].x, fold_neg);
        heading_sine   <= to_q16(link[pwu_pkg::CordSteps].y, fold_neg);
      end
      if (state == pwu_pkg::S_WSUM) weight <= w_new;
      if (state == pwu_pkg::S_DONE && !found) weight <= '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      pwu_pkg::S_IDLE: begin
        if (accept) begin
          obs_x    <= x_value;
          obs_y    <= y_value;
          last_q   <= last;
          red_rem  <= {(heading[31] ? 32'(-heading) : 32'(heading)), 14'b0};
          red_neg  <= heading[31];
          red_step <= 4'd12;
        end
      end
      pwu_pkg::S_REDUCE: begin
        if (red_rem >= red_sub) red_rem <= red_rem - red_sub;
        red_step <= red_step - 4'd1;
      end
      pwu_pkg::S_FOLD: begin
        fold_neg <= fold_neg_c;
        cord_cnt <= '0;
      end
      pwu_pkg::S_CORDIC: cord_cnt <= cord_cnt + 5'd1;
      pwu_pkg::S_XF_MUL: begin
        xc <= obs_x * heading_cosine;
        ys <= obs_y * heading_sine;
        xs <= obs_x * heading_sine;
        yc <= obs_y * heading_cosine;
        r2 <= reach_limit * reach_limit;
      end
      pwu_pkg::S_XF_SUM: begin
        mx        <= sat32(36'(acc_x >>> 16) + 36'(pose_x));
        my        <= sat32(36'(acc_y >>> 16) + 36'(pose_y));
        issue_idx <= '0;
        found     <= 1'b0;
      end
      pwu_pkg::S_SCAN: begin
        if (issue_idx < scan_cnt) begin
          idx1      <= issue_idx[pwu_pkg::AddrW-1:0];
          issue_idx <= issue_idx + 1'b1;
        end
        // squared distances of the slot read last cycle
        if (v1) begin
          sq_ax <= absdiff(lm_x, pose_x) * absdiff(lm_x, pose_x);
          sq_ay <= absdiff(lm_y, pose_y) * absdiff(lm_y, pose_y);
          sq_dx <= absdiff(mx, lm_x) * absdiff(mx, lm_x);
          sq_dy <= absdiff(my, lm_y) * absdiff(my, lm_y);
          idx2  <= idx1;
        end
        // keep the nearest qualifying slot, first one on ties
        if (v2 && qual && (!found || obs_dist < best)) begin
          found   <= 1'b1;
          best    <= obs_dist;
          bslot   <= idx2;
          best_dx <= sq_dx;
          best_dy <= sq_dy;
        end
      end
      pwu_pkg::S_EXP_MUL: begin
        hkx <= best_dx[63:32] * inv_two_var_x;
        lox <= best_dx[31:0] * inv_two_var_x;
        hky <= best_dy[63:32] * inv_two_var_y;
        loy <= best_dy[31:0] * inv_two_var_y;
      end
      pwu_pkg::S_EXP_SUM: begin
        sq_r   <= '0;
        ne_x   <= e_sum[37:6];
        ne_t   <= pwu_pkg::OneQ32;
        ne_sum <= 35'sh1_0000_0000;
        ne_n   <= 5'd1;
      end
      pwu_pkg::S_NE_MUL: ne_v <= ne_prod[63:32];
      pwu_pkg::S_NE_RCP: ne_m <= 65'(ne_v) * 65'(pwu_pkg::recip_q32(ne_n));
      pwu_pkg::S_NE_DIV: begin
        ne_t   <= 33'(q_fix);
        ne_sum <= ne_sum_next;
        ne_n   <= ne_n + 5'd1;
        sq_r   <= ne_sum_next[34] ? '0 : ne_sum_next[32:0];
        sq_cnt <= '0;
      end
      pwu_pkg::S_NE_SQ: begin
        sq_r   <= (sq_r >= pwu_pkg::OneQ32) ? pwu_pkg::OneQ32 : sq_p[64:32];
        sq_cnt <= sq_cnt + 3'd1;
      end
      pwu_pkg::S_GAIN: gain <= gain_p[64:16];
      pwu_pkg::S_WMUL: begin
        p_hi <= weight[47:24] * gain[48:24];
        p_m1 <= weight[47:24] * gain[23:0];
        p_m2 <= weight[23:0] * gain[48:24];
        p_lo <= weight[23:0] * gain[23:0];
      end
      pwu_pkg::S_DONE: begin
        map_x          <= mx;
        map_y          <= my;
        matched_slot   <= found ? 6'(bslot) : '0;
        matched        <= found;
        running_weight <= found ? weight : '0;
        final_res      <= last_q;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/pwu_ram.sv -----
module pwu_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/pwu_cordic_cell.sv -----
module pwu_cordic_cell (
  input  logic             clk,
  input  logic [4:0]       step,
  input  pwu_pkg::cordic_t din,
  output pwu_pkg::cordic_t dout
);

  pwu_pkg::cordic_t nxt;

  // one micro-rotation toward zero residual angle
  always_comb begin
    if (!din.z[pwu_pkg::CordW-1]) begin
      nxt.x = din.x - (din.y >>> step);
      nxt.y = din.y + (din.x >>> step);
      nxt.z = din.z - pwu_pkg::atan_q30(step);
    end else begin
      nxt.x = din.x + (din.y >>> step);
      nxt.y = din.y - (din.x >>> step);
      nxt.z = din.z + pwu_pkg::atan_q30(step);
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule
